/* hw/rtl/btr_pkg.sv */
package btr_pkg;

    // One input request: a pixel, or a padding item after the frame.
    typedef struct packed {
        logic pixel_in;
        logic flush;
    } t_btr_in;

    // One result: the thinned pixel plus end-of-frame status.
    typedef struct packed {
        logic pixel_out;
        logic frame_end;
        logic pass_changed;
    } t_btr_out;

    // Register indexes (byte address bit 2).
    localparam logic BTR_REG_WIDTH  = 1'b0;
    localparam logic BTR_REG_HEIGHT = 1'b1;

    localparam logic [10:0] BTR_MIN_DIM    = 11'd3;
    localparam logic [10:0] BTR_MAX_HEIGHT = 11'd1024;

    localparam int unsigned BTR_SWEEPS    = 3;
    localparam int unsigned BTR_MIN_NBRS  = 2;
    localparam int unsigned BTR_CENTER    = 4;
    localparam int unsigned BTR_CELLS     = 9;

    // 3x3 neighborhood (self included) of each window cell, cell = 3*dy+dx.
    localparam logic [8:0] BTR_CELL_NBRS [BTR_CELLS] = '{
        9'h01B, 9'h03F, 9'h036,
        9'h0DB, 9'h1FF, 9'h1B6,
        9'h0D8, 9'h1F8, 9'h1B0
    };

    // Center may be cleared: all on-neighbors reached from the first one in
    // raster order by three in-place propagation sweeps, and at least two.
    function automatic logic f_removable(input logic [8:0] win);
        logic [8:0] prop;
        int         seed;
        int         cnt;
        seed = BTR_CELLS;
        cnt  = 0;
        for (int i = 0; i < BTR_CELLS; i++) begin
            if (seed == BTR_CELLS && i != BTR_CENTER && win[i]) begin
                seed = i;
            end
            if (win[i]) begin
                cnt = cnt + 1;
            end
        end
        if (seed == BTR_CELLS) begin
            return 1'b0;
        end
        prop       = '0;
        prop[seed] = 1'b1;
        for (int s = 0; s < BTR_SWEEPS; s++) begin
            for (int i = 0; i < BTR_CELLS; i++) begin
                if (prop[i]) begin
                    prop = prop | (BTR_CELL_NBRS[i] & win);
                end
            end
        end
        return (prop == win) && (cnt >= BTR_MIN_NBRS);
    endfunction

    // Indexed by the eight neighbors {cell8..cell5, cell3..cell0}.
    function automatic logic [255:0] f_build_remove_lut();
        logic [255:0] lut;
        logic [7:0]   nb;
        lut = '0;
        for (int idx = 0; idx < 256; idx++) begin
            nb       = 8'(idx);
            lut[idx] = f_removable({nb[7:4], 1'b0, nb[3:0]});
        end
        return lut;
    endfunction

    localparam logic [255:0] BTR_REMOVE_LUT = f_build_remove_lut();

endpackage

/* hw/rtl/binary_thinning_raster_pass_top.sv */
// One in-place raster pass of connectivity-preserving 3x3 thinning over a binary
// image streamed one pixel per request. Program frame_width (byte address 0)
// and frame_height (byte address 4) while idle; each write restarts the pass.
// The block takes one request per clock and sustains one result per clock
// while the result channel does not stall: a request goes through an input
// stage (original-row line buffer read and write) and a window stage
// (final-row line buffer read and write, neighbor lookup) into an output
// register. Results lag the pixel stream by width+1 requests; after each
// frame the host sends width+1 flush requests, the last of which brings out
// the result flagged frame_end with pass_changed. Both line buffers are
// MAX_WIDTH x 1 bit and need no clearing after reset: the first row of
// every frame is a border row, so nothing is read before it is written.
// Repeat passes until pass_changed stays low.
module binary_thinning_raster_pass_top
    import btr_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input pixel channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_btr_in     i_in_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_btr_out    o_out_data,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);   // column index bits
    localparam int unsigned EW = CW + 12;             // clamp compare width
    localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [10:0] r_frame_width;
    logic [10:0] r_frame_height;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 11'd480;
        end else if (cfg_we) begin
            unique case (paddr[2])
                BTR_REG_WIDTH:  r_frame_width  <= pwdata[10:0];
                BTR_REG_HEIGHT: r_frame_height <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            BTR_REG_WIDTH:  prdata = {21'd0, r_frame_width};
            BTR_REG_HEIGHT: prdata = {21'd0, r_frame_height};
            default:        prdata = '0;
        endcase
    end

    // Effective frame size: width clamped to [3, MAX_WIDTH], height to [3, 1024].
    logic [EW-1:0] w_ext;
    logic [EW-1:0] w_clamp;
    logic [CW:0]   eff_w;
    logic [CW:0]   w_m1;
    logic [CW-1:0] w_last;
    logic [10:0]   eff_h;
    logic [10:0]   h_last;

    always_comb begin
        w_ext = {{(CW + 1){1'b0}}, r_frame_width};
        if (w_ext < EW'(BTR_MIN_DIM)) begin
            w_clamp = EW'(BTR_MIN_DIM);
        end else if (w_ext > MAX_W) begin
            w_clamp = MAX_W;
        end else begin
            w_clamp = w_ext;
        end
        eff_w  = w_clamp[CW:0];
        w_m1   = eff_w - (CW + 1)'(1);
        w_last = w_m1[CW-1:0];

        if (r_frame_height < BTR_MIN_DIM) begin
            eff_h = BTR_MIN_DIM;
        end else if (r_frame_height > BTR_MAX_HEIGHT) begin
            eff_h = BTR_MAX_HEIGHT;
        end else begin
            eff_h = r_frame_height;
        end
        h_last = eff_h - 11'd1;
    end

    // ------------------------------------------------------------------
    // Handshake: input stage feeds the window stage, which loads the
    // output register. Requests that complete no window still pass the
    // window stage, since they shift the pixel history.
    // ------------------------------------------------------------------
    logic r_a_vld;
    logic r_o_vld;
    logic in_acc;
    logic out_free;
    logic b_fire;

    assign out_free   = !r_o_vld || !i_out_stall;
    assign b_fire     = r_a_vld && out_free;
    assign o_in_stall = r_a_vld && !b_fire;
    assign in_acc     = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Input stage: raster position of the incoming request and of the
    // pixel whose window it completes (one row and one column behind).
    // ------------------------------------------------------------------
    logic [10:0]   r_row;
    logic [CW-1:0] r_col;

    logic          a_pix;
    logic          a_in_frame;
    logic          a_proc;
    logic [10:0]   a_r;
    logic [CW-1:0] a_c;
    logic          a_interior;
    logic          a_last;
    logic [CW:0]   a_ahead;
    logic [CW:0]   a_ahead_wrap;
    logic [CW-1:0] a_rd;

    always_comb begin
        a_pix      = i_in_data.flush ? 1'b0 : i_in_data.pixel_in;
        a_in_frame = r_row < eff_h;
        a_proc     = (r_row >= 11'd2) || (r_row == 11'd1 && r_col != '0);
        if (r_col != '0) begin
            a_r = r_row - 11'd1;
            a_c = r_col - CW'(1);
        end else begin
            // first column: the window closes on the previous row's last pixel
            a_r = r_row - 11'd2;
            a_c = w_last;
        end
        a_interior = (a_r != 11'd0) && (a_r != h_last) && (a_c != '0) && (a_c != w_last);
        a_last     = (a_r == h_last) && (a_c == w_last);
        // final-row prefetch two columns ahead, wrapping into the next row
        a_ahead      = {1'b0, a_c} + (CW + 1)'(2);
        a_ahead_wrap = (a_ahead >= eff_w) ? (a_ahead - eff_w) : a_ahead;
        a_rd         = a_ahead_wrap[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (cfg_we) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_acc) begin
            if (a_proc && a_last) begin
                r_row <= '0;
                r_col <= '0;
            end else if (r_col == w_last) begin
                r_col <= '0;
                r_row <= r_row + 11'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (in_acc) begin
            r_a_vld <= 1'b1;
        end else if (b_fire) begin
            r_a_vld <= 1'b0;
        end
    end

    // Original-pixel line buffer: read the previous row's pixel in this
    // column, then overwrite it with the current one.
    logic          r_orig_mem [MAX_WIDTH];
    logic          r_a_up;
    logic          r_a_pix;
    logic          r_a_proc;
    logic          r_a_interior;
    logic          r_a_last;
    logic [CW-1:0] r_a_col;
    logic [CW-1:0] r_a_rd;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_up       <= r_orig_mem[r_col];
            if (a_in_frame) begin
                r_orig_mem[r_col] <= a_pix;
            end
            r_a_pix      <= a_pix;
            r_a_proc     <= a_proc;
            r_a_interior <= a_interior;
            r_a_last     <= a_last;
            r_a_col      <= a_c;
            r_a_rd       <= a_rd;
        end
    end

    // ------------------------------------------------------------------
    // Window stage. Cells 0..3 are final values (above row and left),
    // cells 5..8 original values (right and the row below).
    // ------------------------------------------------------------------
    logic r_p1;       // original, row below, center column
    logic r_p2;       // original, row below, left column
    logic r_upp;      // original center pixel
    logic r_f_ur;     // final, above right
    logic r_f_up;     // final, above
    logic r_f_dg;     // final, above left
    logic r_f_left;   // final, left
    logic r_any;

    logic       r_final_mem [MAX_WIDTH];
    logic [7:0] b_nbrs;
    logic       b_removed;
    logic       b_result;

    always_comb begin
        b_nbrs    = {r_a_pix, r_p1, r_p2, r_a_up, r_f_left, r_f_ur, r_f_up, r_f_dg};
        b_removed = r_upp && r_a_interior && BTR_REMOVE_LUT[b_nbrs];
        b_result  = r_upp && !b_removed;
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_p1  <= r_a_pix;
            r_p2  <= r_p1;
            r_upp <= r_a_up;
            if (r_a_proc) begin
                r_final_mem[r_a_col] <= b_result;
                r_f_ur               <= r_final_mem[r_a_rd];
                r_f_up               <= r_f_ur;
                r_f_dg               <= r_f_up;
                r_f_left             <= b_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else if (cfg_we) begin
            r_any <= 1'b0;
        end else if (b_fire && r_a_proc) begin
            if (r_a_last) begin
                r_any <= 1'b0;
            end else if (b_removed) begin
                r_any <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    t_btr_out r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_free) begin
            r_o_vld <= b_fire && r_a_proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire && r_a_proc) begin
            r_o_data.pixel_out    <= b_result;
            r_o_data.frame_end    <= r_a_last;
            r_o_data.pass_changed <= r_a_last && (r_any || b_removed);
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= w_last)
        else $error("column counter past row end");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= eff_h + 11'd1)
        else $error("row counter past flush rows");

    a_changed_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pass_changed |-> o_out_data.frame_end)
        else $error("pass_changed without frame_end");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_a_vld && r_a_proc))
        else $error("result without a completed window");

endmodule
